/* hw/rtl/assert_macros.svh */
// Assertion macros used by the list engine controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked property, disabled while reset is high.
`define BALE_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property that also holds during reset.
`define BALE_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BALE_ASSERT(name, clk, rst, prop, msg)
`define BALE_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

/* hw/rtl/bale_pkg.sv */
// Shared types and constants of the bounded array list engine.
`timescale 1ns / 1ps
package bale_pkg;

   localparam int DATA_W           = 32;
   localparam int OPCODE_W         = 3;
   localparam int POS_W            = 6;
   localparam int STATUS_W         = 2;
   localparam int FOUND_W          = 7;
   localparam int COUNT_W          = 7;
   localparam int CAPACITY_DEFAULT = 64;

   localparam logic [FOUND_W-1:0] FOUND_NONE = {FOUND_W{1'b1}};

   typedef enum logic [OPCODE_W-1:0] {
      OP_APPEND       = 3'd0,
      OP_INSERT       = 3'd1,
      OP_REMOVE_AT    = 3'd2,
      OP_REMOVE_VALUE = 3'd3,
      OP_FIND         = 3'd4,
      OP_READ         = 3'd5,
      OP_CLEAR        = 3'd6
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_RANGE  = 2'd2,
      ST_ABSENT = 2'd3
   } status_type;

   // What every cell does with its word.
   typedef enum logic [2:0] {
      DOP_HOLD       = 3'd0,
      DOP_WRITE      = 3'd1,
      DOP_INSERT     = 3'd2,
      DOP_REMOVE     = 3'd3,
      DOP_REMOVE_HIT = 3'd4
   } data_op_type;

   typedef struct packed {
      data_op_type data_op;
      logic        scan_clear;
      logic        scan_step;
   } cell_ctrl_type;

endpackage

/* hw/rtl/bale_req_if.sv */
// Request channel: opcode, position and value with a valid/ready handshake.
`timescale 1ns / 1ps
interface bale_req_if;
   logic                                valid;
   logic                                ready;
   logic [bale_pkg::OPCODE_W-1:0]       opcode;
   logic [bale_pkg::POS_W-1:0]          position;
   logic signed [bale_pkg::DATA_W-1:0]  value;

   modport source (output valid, output opcode, output position, output value, input ready);
   modport sink   (input valid, input opcode, input position, input value, output ready);
endinterface

/* hw/rtl/bale_rsp_if.sv */
// Response channel: status, found index, read value and count with valid/ready.
`timescale 1ns / 1ps
interface bale_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [bale_pkg::STATUS_W-1:0]       status;
   logic signed [bale_pkg::FOUND_W-1:0] found_index;
   logic signed [bale_pkg::DATA_W-1:0]  read_value;
   logic [bale_pkg::COUNT_W-1:0]        count;

   modport source (output valid, output status, output found_index, output read_value,
                   output count, input ready);
   modport sink   (input valid, input status, input found_index, input read_value,
                   input count, output ready);
endinterface

/* hw/rtl/bale_cell.sv */
// One list cell: holds one word, shifts with its neighbors and tracks the match prefix.
`timescale 1ns / 1ps
module bale_cell #(
   parameter int IDX_W = $clog2(bale_pkg::CAPACITY_DEFAULT),
   parameter int CNT_W = $clog2(bale_pkg::CAPACITY_DEFAULT + 1),
   parameter int INDEX = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bale_pkg::cell_ctrl_type       ctrl,
   input  logic [IDX_W-1:0]              sel,
   input  logic [CNT_W-1:0]              count,
   input  logic [bale_pkg::DATA_W-1:0]   value,
   input  logic [bale_pkg::DATA_W-1:0]   left_data,
   input  logic [bale_pkg::DATA_W-1:0]   right_data,
   input  logic                          left_seen,
   output logic [bale_pkg::DATA_W-1:0]   data,
   output logic                          seen,
   output logic                          first_hit,
   output logic [bale_pkg::DATA_W-1:0]   read_part
);
   import bale_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
   localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);

   logic [DATA_W-1:0] data_ff, data_in;
   logic              seen_ff, seen_in;
   logic              occupied, hit, here, above;

   assign occupied  = MY_CNT < count;
   assign hit       = occupied && (data_ff == value);
   assign here      = MY_IDX == sel;
   assign above     = MY_IDX > sel;
   assign first_hit = hit && !left_seen;
   assign read_part = here ? data_ff : '0;
   assign data      = data_ff;
   assign seen      = seen_ff;

   // The match prefix moves one cell further up the chain on every scan step.
   always_comb begin
      if (ctrl.scan_clear) begin
         seen_in = 1'b0;
      end else if (ctrl.scan_step) begin
         seen_in = left_seen || hit;
      end else begin
         seen_in = seen_ff;
      end
   end

   always_comb begin
      data_in = data_ff;
      unique case (ctrl.data_op)
         DOP_HOLD: begin
            data_in = data_ff;
         end
         DOP_WRITE: begin
            if (here) data_in = value;
         end
         DOP_INSERT: begin
            if (above) data_in = left_data;
            else if (here) data_in = value;
         end
         DOP_REMOVE: begin
            if (above || here) data_in = right_data;
         end
         DOP_REMOVE_HIT: begin
            if (seen_ff) data_in = right_data;
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else begin
         seen_ff <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

/* hw/rtl/bale_ctrl.sv */
// List controller: request holding register, scan sequencing, result logic and response register.
`include "assert_macros.svh"
`timescale 1ns / 1ps
module bale_ctrl #(
   parameter int CAPACITY = bale_pkg::CAPACITY_DEFAULT,
   parameter int IDX_W    = $clog2(CAPACITY),
   parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
   input  logic                                      clock,
   input  logic                                      reset,
   bale_req_if.sink                                  req_port,
   bale_rsp_if.source                                rsp_port,
   input  logic [CAPACITY-1:0]                       first_hit,
   input  logic [CAPACITY-1:0][bale_pkg::DATA_W-1:0] read_part,
   output bale_pkg::cell_ctrl_type                   cell_ctrl,
   output logic [IDX_W-1:0]                          cell_sel,
   output logic [CNT_W-1:0]                          cell_count,
   output logic [bale_pkg::DATA_W-1:0]               cell_value
);
   import bale_pkg::*;

   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   // Word waiting for execution.
   logic                  cur_valid_ff, cur_valid_in;
   logic [OPCODE_W-1:0]   cur_op_ff;
   logic [POS_W-1:0]      cur_pos_ff;
   logic [DATA_W-1:0]     cur_val_ff;

   logic [CNT_W-1:0]      count_ff, count_in, count_next;
   logic [CNT_W-1:0]      scan_cnt_ff, scan_cnt_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [FOUND_W-1:0]    rsp_found_ff;
   logic [DATA_W-1:0]     rsp_read_ff;
   logic [COUNT_W-1:0]    rsp_count_ff;

   logic                  accept, fire, scan_op, scan_done, step, full, pos_ok, hit_any;
   logic [IDX_W-1:0]      hit_index;
   logic [DATA_W-1:0]     read_data;
   status_type            status_in;
   logic [FOUND_W-1:0]    found_in;
   logic [DATA_W-1:0]     read_in;
   data_op_type           data_op;

   assign scan_op   = (cur_op_ff == OP_REMOVE_VALUE) || (cur_op_ff == OP_FIND);
   assign scan_done = scan_cnt_ff == count_ff;
   assign step      = cur_valid_ff && scan_op && !scan_done;
   assign fire      = cur_valid_ff && (!scan_op || scan_done) &&
                      (!rsp_valid_ff || rsp_port.ready);
   assign req_port.ready = !cur_valid_ff || fire;
   assign accept    = req_port.valid && req_port.ready;

   assign full    = count_ff == CNT_W'(CAPACITY);
   assign pos_ok  = CMP_W'(cur_pos_ff) < CMP_W'(count_ff);
   assign hit_any = |first_hit;

   // At most one cell flags the first match once the scan is through.
   always_comb begin
      hit_index = '0;
      read_data = '0;
      for (int j = 0; j < CAPACITY; j++) begin
         if (first_hit[j]) hit_index = hit_index | IDX_W'(j);
         read_data = read_data | read_part[j];
      end
   end

   always_comb begin
      status_in  = ST_OK;
      found_in   = FOUND_NONE;
      read_in    = '0;
      count_next = count_ff;
      data_op    = DOP_HOLD;
      unique case (cur_op_ff)
         OP_APPEND: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               data_op    = DOP_WRITE;
               count_next = count_ff + CNT_W'(1);
            end
         end
         OP_INSERT: begin
            if (full) begin
               status_in = ST_FULL;
            end else if (!pos_ok) begin
               status_in = ST_RANGE;
            end else begin
               data_op    = DOP_INSERT;
               count_next = count_ff + CNT_W'(1);
            end
         end
         OP_REMOVE_AT: begin
            if (!pos_ok) begin
               status_in = ST_RANGE;
            end else begin
               data_op    = DOP_REMOVE;
               count_next = count_ff - CNT_W'(1);
            end
         end
         OP_REMOVE_VALUE: begin
            if (!hit_any) begin
               status_in = ST_ABSENT;
            end else begin
               data_op    = DOP_REMOVE_HIT;
               count_next = count_ff - CNT_W'(1);
            end
         end
         OP_FIND: begin
            if (!hit_any) begin
               status_in = ST_ABSENT;
            end else begin
               found_in = FOUND_W'(hit_index);
            end
         end
         OP_READ: begin
            if (!pos_ok) begin
               status_in = ST_RANGE;
            end else begin
               read_in = read_data;
            end
         end
         OP_CLEAR: begin
            count_next = '0;
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   assign cur_valid_in = accept ? 1'b1 : (fire ? 1'b0 : cur_valid_ff);
   assign scan_cnt_in  = accept ? '0 : (step ? scan_cnt_ff + CNT_W'(1) : scan_cnt_ff);
   assign count_in     = fire ? count_next : count_ff;
   assign rsp_valid_in = fire ? 1'b1 : (rsp_port.ready ? 1'b0 : rsp_valid_ff);

   assign cell_ctrl.data_op    = fire ? data_op : DOP_HOLD;
   assign cell_ctrl.scan_clear = accept;
   assign cell_ctrl.scan_step  = step;
   assign cell_sel   = (cur_op_ff == OP_APPEND) ? IDX_W'(count_ff) : IDX_W'(cur_pos_ff);
   assign cell_count = count_ff;
   assign cell_value = cur_val_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         scan_cnt_ff  <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         scan_cnt_ff  <= scan_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cur_op_ff  <= req_port.opcode;
         cur_pos_ff <= req_port.position;
         cur_val_ff <= req_port.value;
      end
      if (fire) begin
         rsp_status_ff <= status_in;
         rsp_found_ff  <= found_in;
         rsp_read_ff   <= read_in;
         rsp_count_ff  <= COUNT_W'(count_next);
      end
   end

   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.status      = rsp_status_ff;
   assign rsp_port.found_index = rsp_found_ff;
   assign rsp_port.read_value  = rsp_read_ff;
   assign rsp_port.count       = rsp_count_ff;

   `BALE_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(CAPACITY), "count above capacity")
   `BALE_ASSERT(a_scan_bound, clock, reset, (cur_valid_ff && scan_op) |-> (scan_cnt_ff <= count_ff), "scan ran past count")
   `BALE_ASSERT(a_full_no_grow, clock, reset, (fire && status_in == ST_FULL) |=> (count_ff == $past(count_ff)), "full list changed count")
   `BALE_ASSERT(a_single_first, clock, reset, (fire && scan_op) |-> $onehot0(first_hit), "several first matches")
   `BALE_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> (!cur_valid_ff && !rsp_valid_ff && count_ff == '0), "reset left state")

endmodule

/* hw/rtl/bounded_array_list_engine.sv */
// Bounded array list engine: ordered list of signed words in a chain of shifting cells.
// Append, insert, remove at, read and clear: the word passes the request holding register, then its result
// is registered in the response register; one word per cycle while the receiver takes responses. Find and
// remove value scan the match prefix one cell per cycle and take no new word until the scan is through.
// Synchronous active-high reset empties the list and drops any pending word; no clearing pass.
`timescale 1ns / 1ps
module bounded_array_list_engine #(
   parameter int CAPACITY = bale_pkg::CAPACITY_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   bale_req_if.sink    req_port,
   bale_rsp_if.source  rsp_port
);
   import bale_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   cell_ctrl_type                    cell_ctrl;
   logic [IDX_W-1:0]                 cell_sel;
   logic [CNT_W-1:0]                 cell_count;
   logic [DATA_W-1:0]                cell_value;
   logic [CAPACITY-1:0][DATA_W-1:0]  data_w;
   logic [CAPACITY-1:0][DATA_W-1:0]  read_w;
   logic [CAPACITY-1:0]              seen_w;
   logic [CAPACITY-1:0]              first_w;

   bale_ctrl #(
      .CAPACITY (CAPACITY),
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_port   (req_port),
      .rsp_port   (rsp_port),
      .first_hit  (first_w),
      .read_part  (read_w),
      .cell_ctrl  (cell_ctrl),
      .cell_sel   (cell_sel),
      .cell_count (cell_count),
      .cell_value (cell_value)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] left_w;
      logic [DATA_W-1:0] right_w;
      logic              left_seen_w;

      // The head cell never takes from the left; the tail cell refills from itself.
      if (i == 0) begin : g_head
         assign left_w      = cell_value;
         assign left_seen_w = 1'b0;
      end else begin : g_body
         assign left_w      = data_w[i-1];
         assign left_seen_w = seen_w[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_w = data_w[i];
      end else begin : g_inner
         assign right_w = data_w[i+1];
      end

      bale_cell #(
         .IDX_W (IDX_W),
         .CNT_W (CNT_W),
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl),
         .sel        (cell_sel),
         .count      (cell_count),
         .value      (cell_value),
         .left_data  (left_w),
         .right_data (right_w),
         .left_seen  (left_seen_w),
         .data       (data_w[i]),
         .seen       (seen_w[i]),
         .first_hit  (first_w[i]),
         .read_part  (read_w[i])
      );
   end

endmodule

/* dv/testbench.sv */
// Self-checking testbench of the bounded array list engine.
`timescale 1ns / 1ps
module testbench;
   import bale_pkg::*;

   localparam int LIST_DEPTH = CAPACITY_DEFAULT;
   localparam logic [OPCODE_W-1:0] OP_UNUSED = 3'd7;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int REPORT_LIMIT = 10;

   typedef struct {
      status_type                 status;
      logic signed [FOUND_W-1:0]  found_index;
      logic signed [DATA_W-1:0]   read_value;
      logic [COUNT_W-1:0]         count;
   } list_reply_type;

   logic clock = 1'b0;
   logic reset;

   bale_req_if req_ch ();
   bale_rsp_if rsp_ch ();

   bounded_array_list_engine DUT (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch),
      .rsp_port (rsp_ch)
   );

   // Predictor state: the words of the list in order.
   logic signed [DATA_W-1:0] list_words[$];
   list_reply_type           predicted_replies[$];

   int mismatch_count = 0;
   int reply_count = 0;
   int cycle_count = 0;
   int burst_left;
   logic [31:0] ready_mask;
   int          ready_phase = 0;
   bit          ready_free;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Applies one word to the predicted list and returns the reply it should cause.
   function automatic list_reply_type apply_list_op(logic [OPCODE_W-1:0] op,
                                                    logic [POS_W-1:0] pos,
                                                    logic signed [DATA_W-1:0] val);
      list_reply_type r;
      int hit;
      r.status      = ST_OK;
      r.found_index = FOUND_NONE;
      r.read_value  = '0;
      hit = -1;
      foreach (list_words[i]) begin
         if (hit < 0 && list_words[i] == val) hit = i;
      end
      case (op)
         OP_APPEND: begin
            if (list_words.size() >= LIST_DEPTH) r.status = ST_FULL;
            else list_words.push_back(val);
         end
         OP_INSERT: begin
            if (list_words.size() >= LIST_DEPTH) r.status = ST_FULL;
            else if (pos >= list_words.size()) r.status = ST_RANGE;
            else list_words.insert(pos, val);
         end
         OP_REMOVE_AT: begin
            if (pos >= list_words.size()) r.status = ST_RANGE;
            else list_words.delete(pos);
         end
         OP_REMOVE_VALUE: begin
            if (hit < 0) r.status = ST_ABSENT;
            else list_words.delete(hit);
         end
         OP_FIND: begin
            if (hit < 0) r.status = ST_ABSENT;
            else r.found_index = FOUND_W'(hit);
         end
         OP_READ: begin
            if (pos >= list_words.size()) r.status = ST_RANGE;
            else r.read_value = list_words[pos];
         end
         OP_CLEAR: begin
            list_words.delete();
         end
         default: begin
         end
      endcase
      r.count = COUNT_W'(list_words.size());
      return r;
   endfunction

   // Sends one word in bursts with random gaps; called and returns at a falling edge.
   task automatic send_word(input logic [OPCODE_W-1:0] op, input logic [POS_W-1:0] pos,
                            input logic signed [DATA_W-1:0] val);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_ch.valid    = 1'b1;
      req_ch.opcode   = op;
      req_ch.position = pos;
      req_ch.value    = val;
      do @(posedge clock); while (!req_ch.ready);
      predicted_replies.push_back(apply_list_op(op, pos, val));
      @(negedge clock);
   endtask

   // Receiver stalls follow a random mask redrawn for each window; some windows never stall.
   always @(negedge clock) begin
      if (ready_phase == 0) begin
         ready_mask  = $urandom;
         ready_free  = ($urandom_range(0, 3) == 0);
         ready_phase = 16;
      end
      ready_phase--;
      rsp_ch.ready = ready_free || ready_mask[ready_phase] || ready_mask[ready_phase + 16];
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         list_reply_type exp_reply;
         reply_count++;
         if (predicted_replies.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("Reply %0d arrived with no word outstanding", reply_count);
         end else begin
            exp_reply = predicted_replies.pop_front();
            if (rsp_ch.status !== exp_reply.status
                || rsp_ch.found_index !== exp_reply.found_index
                || rsp_ch.read_value !== exp_reply.read_value
                || rsp_ch.count !== exp_reply.count) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("Reply %0d: expected status %0d index %0d read %0d count %0d, %s",
                           reply_count, exp_reply.status, exp_reply.found_index,
                           exp_reply.read_value, exp_reply.count,
                           $sformatf("got status %0d index %0d read %0d count %0d",
                                     rsp_ch.status, rsp_ch.found_index,
                                     rsp_ch.read_value, rsp_ch.count));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Field extremes, every operation and the range, absent and empty cases on a short list.
   task automatic test_directed_ops();
      send_word(OP_APPEND, 6'd0, 32'sh7FFF_FFFF);
      send_word(OP_APPEND, 6'd63, 32'sh8000_0000);
      send_word(OP_APPEND, 6'd0, 32'sh0000_0000);
      send_word(OP_APPEND, 6'd0, -32'sd1);
      send_word(OP_APPEND, 6'd0, 32'sd5);
      send_word(OP_READ, 6'd0, 32'sd0);
      send_word(OP_READ, 6'd4, 32'sd0);
      send_word(OP_READ, 6'd5, 32'sd0);
      send_word(OP_READ, 6'd63, -32'sd1);
      send_word(OP_FIND, 6'd0, 32'sh8000_0000);
      send_word(OP_FIND, 6'd0, 32'sd12345);
      send_word(OP_INSERT, 6'd0, 32'sd7);
      send_word(OP_INSERT, 6'd6, 32'sd8);
      send_word(OP_INSERT, 6'd63, 32'sd9);
      send_word(OP_REMOVE_AT, 6'd63, 32'sd0);
      send_word(OP_REMOVE_AT, 6'd0, 32'sd0);
      send_word(OP_REMOVE_VALUE, 6'd0, -32'sd1);
      send_word(OP_REMOVE_VALUE, 6'd0, 32'sd999);
      send_word(OP_APPEND, 6'd0, 32'sd5);
      send_word(OP_FIND, 6'd0, 32'sd5);
      send_word(OP_UNUSED, 6'd17, 32'sh5A5A_A5A5);
      send_word(OP_CLEAR, 6'd0, 32'sd0);
      send_word(OP_READ, 6'd0, 32'sd0);
      send_word(OP_REMOVE_AT, 6'd0, 32'sd0);
      send_word(OP_FIND, 6'd0, 32'sd0);
   endtask

   // Fills the list to capacity, then tries every operation at the full and near-full edges.
   task automatic test_full_list();
      int i;
      logic signed [DATA_W-1:0] last_word;
      send_word(OP_CLEAR, 6'd0, 32'sd0);
      for (i = 0; i < LIST_DEPTH; i++) begin
         last_word = $urandom;
         send_word(OP_APPEND, POS_W'($urandom_range(0, 63)), last_word);
      end
      send_word(OP_APPEND, 6'd0, 32'sd1);
      send_word(OP_INSERT, 6'd63, 32'sd2);
      send_word(OP_INSERT, 6'd0, 32'sd3);
      send_word(OP_FIND, 6'd0, last_word);
      send_word(OP_READ, 6'd63, 32'sd0);
      send_word(OP_REMOVE_AT, 6'd63, 32'sd0);
      send_word(OP_READ, 6'd63, 32'sd0);
      send_word(OP_INSERT, 6'd62, 32'sh8000_0000);
      send_word(OP_APPEND, 6'd0, 32'sd4);
      send_word(OP_REMOVE_VALUE, 6'd0, list_words[0]);
      send_word(OP_INSERT, 6'd63, 32'sh7FFF_FFFF);
      send_word(OP_INSERT, 6'd0, 32'sd0);
      send_word(OP_FIND, 6'd0, 32'sh7FFF_FFFF);
      send_word(OP_CLEAR, 6'd0, 32'sd0);
   endtask

   // Random mix that mostly hits stored words and live positions so the list fills and drains.
   task automatic test_random_traffic(input int word_total);
      int n;
      int roll;
      int size;
      logic [OPCODE_W-1:0]      op;
      logic [POS_W-1:0]         pos;
      logic signed [DATA_W-1:0] val;
      for (n = 0; n < word_total; n++) begin
         size = list_words.size();
         roll = $urandom_range(0, 99);
         if (roll < 26)      op = OP_APPEND;
         else if (roll < 40) op = OP_INSERT;
         else if (roll < 51) op = OP_REMOVE_AT;
         else if (roll < 62) op = OP_REMOVE_VALUE;
         else if (roll < 77) op = OP_FIND;
         else if (roll < 97) op = OP_READ;
         else if (roll < 98) op = OP_CLEAR;
         else                op = OP_UNUSED;
         if (size > 0 && $urandom_range(0, 9) < 8) pos = POS_W'($urandom_range(0, size - 1));
         else pos = POS_W'($urandom_range(0, 63));
         case ($urandom_range(0, 3))
            0, 1: val = (size > 0) ? list_words[$urandom_range(0, size - 1)] : $urandom;
            2: val = $signed($urandom_range(0, 7)) - 32'sd4;
            default: val = $urandom;
         endcase
         send_word(op, pos, val);
      end
   endtask

   initial begin
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.opcode   = '0;
      req_ch.position = '0;
      req_ch.value    = '0;
      burst_left      = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_ops();
      test_full_list();
      test_random_traffic(750);
      req_ch.valid = 1'b0;

      while (predicted_replies.size() != 0) @(posedge clock);
      // A scan over a full list is the longest latency.
      repeat (LIST_DEPTH + 8) @(posedge clock);
      if (mismatch_count == 0 && predicted_replies.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
